// ===== rtl/core/drbh_pkg.sv =====
// ============================================================================
// drbh_pkg
// Shared widths, constants and types for the dual register byte hash core.
// ============================================================================
`default_nettype none

package drbh_pkg;

  localparam int unsigned HashW  = 24;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutW   = 32;
  localparam int unsigned FoldSh = 12;

  localparam logic [HashW-1:0] HighInit = 24'h0045D9;
  localparam logic [HashW-1:0] LowInit  = 24'h002710;
  localparam logic [HashW-1:0] XorAdd   = 24'd17;
  localparam logic [ByteW-1:0] LowMult  = 8'd131;
  localparam logic [ByteW-1:0] HighMult = 8'd33;
  localparam logic [ByteW-1:0] LowFold  = 8'd17;

  typedef logic [HashW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [OutW-1:0]  hash_t;

  // operands of the shared multiply-add unit: y = a * k + c (mod 2^24)
  typedef struct packed {
    word_t a;
    byte_t k;
    word_t c;
  } mac_op_t;

  // one-hot sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_STEP1 = 6'b000010,
    ST_STEP2 = 6'b000100,
    ST_STEP3 = 6'b001000,
    ST_STEP4 = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/drbh_if.sv =====
// ============================================================================
// drbh_in_if / drbh_out_if
// Valid/ready channels for message bytes and hash results.
// ============================================================================
`default_nettype none

interface drbh_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic              byte_present;
  logic              last;

  modport source (output valid, output data_byte, output byte_present, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_present, input last,
                  output ready);
endinterface

interface drbh_out_if;
  logic              valid;
  logic              ready;
  logic [31:0]       hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dual_register_byte_hash_core.sv =====
// ============================================================================
// dual_register_byte_hash_core
// Byte-serial dual register hash with one shared multiply-add unit.
// ============================================================================
// A message arrives one byte per request on in_ch; a request with last set
// closes the message and yields one 32-bit hash on out_ch, after which the
// hash registers return to their start values. A request that carries a byte
// passes through the accept state and four update steps, all done by one
// 24x8 multiply-add unit in turn, so that unit sets the byte rate. A closing
// request adds an emit state, which waits while the previous result is still
// held in the output register. A request with neither byte nor last is taken
// in the idle state and has no effect. in_ch.ready is high only while idle.
`default_nettype none

module dual_register_byte_hash_core (
  input  wire         clk,
  input  wire         rst_n,
  drbh_in_if.sink     in_ch,
  drbh_out_if.source  out_ch
);
  import drbh_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // hash state and the latched request
  word_t  high_r, high_nxt;
  word_t  low_r,  low_nxt;
  word_t  pos_r,  pos_nxt;
  byte_t  byte_r, byte_nxt;
  logic   last_r, last_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  hash_t  out_hash_r,  out_hash_nxt;

  mac_op_t mac_op;
  word_t   mac_y;
  logic    in_acc;
  logic    out_free;
  hash_t   fold;

  drbh_mac u_mac (
    .op (mac_op),
    .y  (mac_y)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;
  assign out_free          = !out_valid_r || out_ch.ready;

  // (high << 12) + low, truncated to 32 bits
  assign fold = {high_r[OutW-FoldSh-1:0], {FoldSh{1'b0}}} + {{(OutW-HashW){1'b0}}, low_r};

  // operand selection for the shared unit, one step per state
  always_comb begin
    mac_op = '{a: '0, k: '0, c: '0};
    case (state_r)
      ST_STEP1: mac_op = '{a: pos_r, k: byte_r, c: XorAdd};
      ST_STEP2: mac_op = '{a: {{(HashW-ByteW){1'b0}}, byte_r} + pos_r - word_t'(1),
                           k: LowMult, c: low_r};
      ST_STEP3: mac_op = '{a: high_r, k: HighMult, c: low_r};
      ST_STEP4: mac_op = '{a: low_r, k: LowFold, c: high_r};
      default:  mac_op = '{a: '0, k: '0, c: '0};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    pos_nxt       = pos_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          byte_nxt = in_ch.data_byte;
          last_nxt = in_ch.last;
          if (in_ch.byte_present) begin
            // position now holds i, counted from one
            pos_nxt   = pos_r + word_t'(1);
            state_nxt = ST_STEP1;
          end else if (in_ch.last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_STEP1: begin
        high_nxt  = high_r ^ mac_y;
        state_nxt = ST_STEP2;
      end
      ST_STEP2: begin
        low_nxt   = mac_y;
        state_nxt = ST_STEP3;
      end
      ST_STEP3: begin
        high_nxt  = mac_y;
        state_nxt = ST_STEP4;
      end
      ST_STEP4: begin
        low_nxt   = mac_y;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = fold;
          high_nxt      = HighInit;
          low_nxt       = LowInit;
          pos_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      high_r      <= HighInit;
      low_r       <= LowInit;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // a byte request always starts the four-step update
  a_byte_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.byte_present |=> state_r == ST_STEP1)
    else $error("byte request did not start update");

  // an empty closing request goes straight to emit
  a_empty_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_ch.byte_present && in_ch.last |=> state_r == ST_EMIT)
    else $error("empty closing request did not reach emit");

  // emitting a result puts the hash state back to its start values
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free |=>
      high_r == HighInit && low_r == LowInit && pos_r == '0 && out_valid_r)
    else $error("emit did not clear hash state");

  // last update step leaves the sequencer only towards idle or emit
  a_step4_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP4 |=> state_r == ST_IDLE || state_r == ST_EMIT)
    else $error("bad exit from final update step");

endmodule

`default_nettype wire

// ===== rtl/core/drbh_mac.sv =====
// ============================================================================
// drbh_mac
// Shared multiply-add unit, 24 by 8 bit product plus 24 bit addend, mod 2^24.
// ============================================================================
`default_nettype none

module drbh_mac (
  input  drbh_pkg::mac_op_t op,
  output drbh_pkg::word_t   y
);
  import drbh_pkg::*;

  logic [HashW+ByteW-1:0] prod;

  assign prod = {{ByteW{1'b0}}, op.a} * {{HashW{1'b0}}, op.k};
  assign y    = prod[HashW-1:0] + op.c;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for dual_register_byte_hash_core.
// ============================================================================
// Messages are sent one byte per request, and each one is closed by a request
// with last set. A local copy of the two hash registers and the byte position
// predicts every 32-bit hash, which is queued when the closing request is
// accepted and compared with the next result that leaves the core. Both
// channels idle at random, with one steady stretch, one long output stall
// and a full drain between tests.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import drbh_pkg::*;

  localparam int DrainCycles  = 16;   // margin for a byte update and an emit to finish
  localparam int IdlePercent  = 16;
  localparam int MaxReports   = 10;

  logic clk = 1'b0;
  logic rst_n;

  drbh_in_if  in_ch ();
  drbh_out_if out_ch ();

  dual_register_byte_hash_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // predicted hash state of the message in flight
  word_t msg_high;
  word_t msg_low;
  word_t msg_position;

  hash_t pending_hashes[$];   // hashes owed by the core, oldest first

  int  mismatch_count  = 0;
  int  stray_count     = 0;
  int  hashes_checked  = 0;
  int  bytes_sent      = 0;
  int  messages_sent   = 0;
  int  noise_sent      = 0;
  int  hold_left       = 0;   // cycles the result side still holds off
  bit  sender_calm     = 1'b0;
  bit  receiver_calm   = 1'b0;

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------
  function automatic void restart_message();
    msg_high     = HighInit;
    msg_low      = LowInit;
    msg_position = '0;
  endfunction

  // one byte through the four dependent update steps, all mod 2^24
  function automatic void absorb_byte(input byte_t data);
    word_t idx;
    word_t prod;
    word_t h;
    word_t l;
    idx  = msg_position + word_t'(1);
    prod = word_t'(data) * idx;
    h    = msg_high ^ (prod + XorAdd);
    l    = msg_low + (word_t'(data) + idx - word_t'(1)) * word_t'(LowMult);
    h    = h * word_t'(HighMult) + l;
    l    = l * word_t'(LowFold) + h;
    msg_high     = h;
    msg_low      = l;
    msg_position = idx;
  endfunction

  // fold the two registers into the 32-bit result and start afresh
  function automatic hash_t close_message();
    hash_t folded;
    folded = (hash_t'(msg_high) << FoldSh) + hash_t'(msg_low);
    restart_message();
    return folded;
  endfunction

  // --------------------------------------------------------------------------
  // result side: ready pattern, with long hold-offs counted here
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (receiver_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  // every accepted result against the oldest prediction
  always @(posedge clk) begin : check_results
    hash_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        stray_count = stray_count + 1;
        if (mismatch_count + stray_count <= MaxReports)
          $display("[%0t] result 0x%08h with no message closed", $time, out_ch.hash_value);
      end else begin
        want = pending_hashes.pop_front();
        hashes_checked = hashes_checked + 1;
        if (out_ch.hash_value !== want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count + stray_count <= MaxReports)
            $display("[%0t] hash_value expected 0x%08h got 0x%08h",
                     $time, want, out_ch.hash_value);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  // called and left at a falling edge; predicts once the request is taken
  task automatic send_request(input byte_t data, input bit present, input bit closing);
    int    gap;
    hash_t owed;
    if (!sender_calm && $urandom_range(0, 99) < IdlePercent) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= data;
    in_ch.byte_present <= present;
    in_ch.last         <= closing;
    do @(posedge clk); while (!in_ch.ready);
    if (present) begin
      absorb_byte(data);
      bytes_sent = bytes_sent + 1;
    end
    if (closing) begin
      owed = close_message();
      pending_hashes = {pending_hashes, owed};
      messages_sent = messages_sent + 1;
    end
    if (!present && !closing)
      noise_sent = noise_sent + 1;
    @(negedge clk);
  endtask

  // a message of random bytes with the odd empty request mixed in; it is closed
  // either on its last byte or by a separate request without a byte
  task automatic send_message(input int len, input bit empty_close);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 5)
        send_request(byte_t'($urandom), 1'b0, 1'b0);
      send_request(byte_t'($urandom), 1'b1, (k == len - 1) && !empty_close);
    end
    if (empty_close || len == 0)
      send_request(byte_t'($urandom), 1'b0, 1'b1);
  endtask

  // sender stands still until every hash is back and the core has settled
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_request(8'h3C, 1'b0, 1'b1);          // empty message gives the start value
    send_request(8'h00, 1'b1, 1'b1);          // lowest byte, closed on the byte
    send_request(8'hFF, 1'b1, 1'b1);          // highest byte
    send_request(8'hAA, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);          // neither byte nor last: no effect
    send_request(8'h55, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);          // closed without a byte
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h01, 1'b1, 1'b1);
    send_request(8'h7F, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);          // data bits ignored without byte_present
    send_request(8'hFF, 1'b0, 1'b1);          // two empty messages back to back
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b1);
    wait_drained();
  endtask

  // bulk of the run: mostly short messages, some empty, some long
  task automatic test_random_messages(input int target_bytes);
    int stop_at;
    int pick;
    int len;
    stop_at = bytes_sent + target_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)       len = 0;
      else if (pick < 90)  len = $urandom_range(1, 16);
      else                 len = $urandom_range(17, 64);
      send_message(len, $urandom_range(0, 99) < 30);
    end
    wait_drained();
  endtask

  // no idling on either side for a good stretch
  task automatic test_steady_stream();
    sender_calm   = 1'b1;
    receiver_calm = 1'b1;
    for (int m = 0; m < 12; m++)
      send_message($urandom_range(1, 20), $urandom_range(0, 1));
    wait_drained();
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // result side shut for a long time while short messages keep coming, so the
  // output register fills and the core stops taking requests
  task automatic test_output_stall();
    hold_left = 400;
    for (int m = 0; m < 15; m++)
      send_message($urandom_range(0, 3), $urandom_range(0, 1));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last         = 1'b0;
    out_ch.ready       = 1'b0;
    restart_message();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_messages(1200);
    test_steady_stream();
    test_output_stall();
    test_random_messages(150);

    $display("covered %0d messages, %0d bytes and %0d empty requests; %0d hashes checked",
             messages_sent, bytes_sent, noise_sent, hashes_checked);
    $display("random idling on both sides, one steady stretch, one long output stall");
    if (mismatch_count == 0 && stray_count == 0 && pending_hashes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d wrong, %0d unexpected, %0d missing",
               mismatch_count, stray_count, pending_hashes.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("timeout with %0d hashes outstanding", pending_hashes.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
